FILE: src/hrbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrbe_pkg;

  // Sizing
  localparam int MAX_HEADER = 8192;
  localparam int LEN_BITS   = 32;
  localparam int HCNT_W     = $clog2(MAX_HEADER + 1);
  localparam int OUT_LEN_W  = 32;
  localparam int LEN_EXT_W  = (LEN_BITS > OUT_LEN_W) ? LEN_BITS : OUT_LEN_W;
  localparam int NAME_LEN   = 16;
  localparam int NAME_POS_W = $clog2(NAME_LEN);
  localparam int DELIM_LEN  = 4;
  localparam int DELIM_W    = $clog2(DELIM_LEN);
  localparam int KIND_W     = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_BODY      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HDR_OK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NO_LENGTH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_HDR_LONG  = 2'd3;

  // Phase codes
  localparam logic PH_HEADER = 1'b0;
  localparam logic PH_BODY   = 1'b1;

  // Length parse states
  localparam logic [1:0] LS_NONE   = 2'd0;
  localparam logic [1:0] LS_BLANK  = 2'd1;
  localparam logic [1:0] LS_DIGITS = 2'd2;
  localparam logic [1:0] LS_DONE   = 2'd3;

  // Characters
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;

  localparam logic [7:0] NAME_PAT [NAME_LEN] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
  };

  localparam logic [7:0] DELIM_PAT [DELIM_LEN] = '{CH_CR, CH_LF, CH_CR, CH_LF};

  // One result beat
  typedef struct packed {
    logic                 vld;
    logic [KIND_W-1:0]    kind;
    logic [7:0]           body_byte;
    logic [OUT_LEN_W-1:0] body_length;
    logic                 last;
  } result_t;

  // Clamp the internal length to the 32-bit result field
  function automatic logic [OUT_LEN_W-1:0] len_to_out(input logic [LEN_BITS-1:0] v);
    logic [LEN_EXT_W-1:0] e;
    e = LEN_EXT_W'(v);
    if (e > LEN_EXT_W'({OUT_LEN_W{1'b1}})) begin
      return {OUT_LEN_W{1'b1}};
    end
    return e[OUT_LEN_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/hrbe_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module hrbe_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  output hrbe_pkg::result_t     res_o
);
  import hrbe_pkg::*;

  logic                  phase_r,      phase_nxt;
  logic [DELIM_W-1:0]    dm_r,         dm_nxt;
  logic [NAME_POS_W-1:0] npos_r,       npos_nxt;
  logic [1:0]            ls_r,         ls_nxt;
  logic [LEN_BITS-1:0]   lv_r,         lv_nxt;
  logic [HCNT_W-1:0]     hcnt_r,       hcnt_nxt;
  logic [LEN_BITS-1:0]   rem_r,        rem_nxt;

  logic [LEN_BITS+3:0]   mac;
  logic                  is_digit;
  logic                  fin;
  logic                  delim_done;
  logic [HCNT_W-1:0]     hcnt_inc;
  logic [LEN_BITS-1:0]   ls_val;
  logic [1:0]            ls_scan;
  logic [NAME_POS_W-1:0] npos_scan;

  // Decimal accumulate: v*10 + digit, saturating at all ones
  assign is_digit = (byte_i >= CH_0) && (byte_i <= CH_9);
  assign mac = ((LEN_BITS+4)'(lv_r) << 3) + ((LEN_BITS+4)'(lv_r) << 1)
             + (LEN_BITS+4)'(byte_i - CH_0);

  assign fin        = (rem_r <= LEN_BITS'(1));
  assign delim_done = (dm_r == DELIM_W'(DELIM_LEN - 1)) && (byte_i == CH_LF);
  assign hcnt_inc   = hcnt_r + HCNT_W'(1);

  // Content-Length name match and value parse
  always_comb begin
    ls_scan   = ls_r;
    ls_val    = lv_r;
    npos_scan = npos_r;
    unique case (ls_r)
      LS_NONE: begin
        if (byte_i == NAME_PAT[npos_r]) begin
          if (npos_r == NAME_POS_W'(NAME_LEN - 1)) begin
            ls_scan   = LS_BLANK;
            ls_val    = '0;
            npos_scan = '0;
          end else begin
            npos_scan = npos_r + NAME_POS_W'(1);
          end
        end else begin
          npos_scan = (byte_i == NAME_PAT[0]) ? NAME_POS_W'(1) : '0;
        end
      end
      LS_BLANK, LS_DIGITS: begin
        if (is_digit) begin
          ls_val  = (|mac[LEN_BITS+3:LEN_BITS]) ? {LEN_BITS{1'b1}} : mac[LEN_BITS-1:0];
          ls_scan = LS_DIGITS;
        end else if ((ls_r == LS_BLANK) && ((byte_i == CH_SP) || (byte_i == CH_TAB))) begin
          ls_scan = LS_BLANK;
        end else begin
          ls_scan = LS_DONE;
        end
      end
      LS_DONE: begin
        ls_scan = LS_DONE;
      end
      default: begin
        ls_scan = ls_r;
      end
    endcase
  end

  // Next state and result for one byte
  always_comb begin
    phase_nxt = phase_r;
    dm_nxt    = dm_r;
    npos_nxt  = npos_r;
    ls_nxt    = ls_r;
    lv_nxt    = lv_r;
    hcnt_nxt  = hcnt_r;
    rem_nxt   = rem_r;
    res_o     = '0;

    if (phase_r == PH_BODY) begin
      res_o.vld       = 1'b1;
      res_o.kind      = KIND_BODY;
      res_o.body_byte = byte_i;
      res_o.last      = fin;
      if (fin) begin
        phase_nxt = PH_HEADER;
        rem_nxt   = '0;
      end else begin
        rem_nxt = rem_r - LEN_BITS'(1);
      end
    end else begin
      hcnt_nxt = hcnt_inc;
      npos_nxt = npos_scan;
      ls_nxt   = ls_scan;
      lv_nxt   = ls_val;
      if (byte_i == DELIM_PAT[dm_r]) begin
        dm_nxt = dm_r + DELIM_W'(1);
      end else begin
        dm_nxt = (byte_i == CH_CR) ? DELIM_W'(1) : '0;
      end

      if (delim_done || (32'(hcnt_inc) >= 32'(MAX_HEADER))) begin
        res_o.vld = 1'b1;
        res_o.last = 1'b1;
        if (!delim_done) begin
          res_o.kind = KIND_HDR_LONG;
        end else if (ls_scan == LS_NONE) begin
          res_o.kind = KIND_NO_LENGTH;
        end else begin
          res_o.kind        = KIND_HDR_OK;
          res_o.body_length = len_to_out(ls_val);
          res_o.last        = (ls_val == '0);
          if (ls_val != '0) begin
            phase_nxt = PH_BODY;
            rem_nxt   = ls_val;
          end
        end
        // re-arm the header scan
        dm_nxt   = '0;
        npos_nxt = '0;
        ls_nxt   = LS_NONE;
        lv_nxt   = '0;
        hcnt_nxt = '0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      dm_r    <= '0;
      npos_r  <= '0;
      ls_r    <= LS_NONE;
      lv_r    <= '0;
      hcnt_r  <= '0;
      rem_r   <= '0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      dm_r    <= dm_nxt;
      npos_r  <= npos_nxt;
      ls_r    <= ls_nxt;
      lv_r    <= lv_nxt;
      hcnt_r  <= hcnt_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // Checks
  a_body_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> rem_r != '0)
    else $error("body phase with no bytes remaining");

  a_body_header_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> (hcnt_r == '0) && (ls_r == LS_NONE) && (npos_r == '0))
    else $error("header scan state not cleared in body phase");

  a_hcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(hcnt_r) < 32'(MAX_HEADER))
    else $error("header count past limit");

  a_ok_enters_body: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && res_o.vld && (res_o.kind == KIND_HDR_OK) && !res_o.last |=> phase_r == PH_BODY)
    else $error("nonzero length did not start body");

endmodule

`default_nettype wire

FILE: src/http_response_body_extractor.sv
`timescale 1ns / 1ps
`default_nettype none
// A beat taken on in_* goes first into the input register and then into the result
// register, from which it is offered on out_*.
// Throughput: one byte per cycle while no result waits on out_tready; the input
// and result registers still let a byte be taken while an earlier result waits.
// Header bytes give no result except the status beat on the closing byte
// or on the byte that reaches the header limit.
// Reset (rst_n low, synchronous) empties both registers and re-arms header search.
module http_response_body_extractor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  output wire logic        out_tvalid,
  input  wire logic        out_tready,
  output wire logic [39:0] out_tdata,  // [7:0] body_byte, [39:8] body_length
  output wire logic [1:0]  out_tuser,  // [1:0] kind
  output wire logic        out_tlast   // last
);
  import hrbe_pkg::*;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        adv;
  logic        step;
  result_t     res;
  result_t     out_nxt;
  result_t     out_r;

  assign adv       = !out_r.vld || out_tready;
  assign step      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  hrbe_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .byte_i (in_byte_r),
    .res_o  (res)
  );

  // Result register
  always_comb begin
    out_nxt     = res;
    out_nxt.vld = step && res.vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_r.vld;
  assign out_tdata  = {out_r.body_length, out_r.body_byte};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

endmodule

`default_nettype wire
